// ===== src/rsic_pkg.sv =====
package rsic_pkg;

    // Default size of the byte-addressed data memory.
    localparam int unsigned DataBytesDef = 65536;

    typedef enum logic [1:0] {
        CMD_EXEC    = 2'd0,
        CMD_WR_BYTE = 2'd1,
        CMD_RD_BYTE = 2'd2,
        CMD_RD_REG  = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_HALTED  = 2'd2
    } t_status;

    localparam logic [5:0] OP_RTYPE = 6'h00;
    localparam logic [5:0] OP_J     = 6'h02;
    localparam logic [5:0] OP_BEQ   = 6'h04;
    localparam logic [5:0] OP_ADDIU = 6'h09;
    localparam logic [5:0] OP_LW    = 6'h23;
    localparam logic [5:0] OP_SW    = 6'h2B;

    // R-type operations are told apart by the low three funct bits only.
    localparam logic [2:0] FN_ADDU = 3'd1;
    localparam logic [2:0] FN_SUBU = 3'd3;
    localparam logic [2:0] FN_AND  = 3'd4;
    localparam logic [2:0] FN_OR   = 3'd5;
    localparam logic [2:0] FN_NOR  = 3'd7;

    localparam logic [31:0] WORD_HALT = 32'hFFFF_FFFF;

endpackage

// ===== src/risc_subset_instruction_core.sv =====
// Executes a small 32-bit load/store instruction set, one instruction per item.
// Input channel s_axis: tuser carries the command (execute, write data byte,
// read data byte, read register); tdata carries the instruction fetched at the
// last reported pc plus the operands of the other commands. Every accepted item
// yields exactly one result item on m_axis, in order.
// An item is registered in the execute stage and its result in the output
// register; lw and the data byte read pass through the completion stage in
// between. Non-memory items can be taken every cycle unless the output stalls;
// lw and the data byte read take no new item until they leave completion.
// The register file is a two-read, one-write memory read in the accept cycle,
// with a bypass for a write landing on the same edge; the data memory is four
// byte-wide banks so that an unaligned big-endian word is one access.
// DATA_BYTES must be a power of two; every data address wraps to it.
// Reset clears the pc, the halted flag, the register valid bits and all pipeline
// valid flags; the data memory is not cleared and is undefined until written.
// When the receiver stalls, the finished result waits in the output register
// and one more item is still accepted and held in the execute stage.
module risc_subset_instruction_core #(
    parameter int unsigned DATA_BYTES = rsic_pkg::DataBytesDef
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // instruction[31:0], mem_address[47:32], mem_byte[55:48], reg_index[60:56], zero
    input  logic [63:0]  s_axis_tdata,
    // command[1:0]
    input  logic [1:0]   s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // next_pc[31:0], status[33:32], read_value[65:34], reg_written[66],
    // dest_reg[71:67], dest_value[103:72]
    output logic [103:0] m_axis_tdata
);

    localparam int unsigned AW   = $clog2(DATA_BYTES);
    localparam int unsigned RW   = AW - 2;
    localparam int unsigned ROWS = DATA_BYTES / 4;

    // Input side decode.
    rsic_pkg::t_cmd in_cmd;
    logic [31:0]    in_ins;
    logic [15:0]    in_maddr;
    logic [7:0]     in_mbyte;
    logic [4:0]     in_ridx;
    logic [4:0]     rd_addr_a;
    logic [4:0]     rd_addr_b;
    logic           accept;

    assign in_cmd    = rsic_pkg::t_cmd'(s_axis_tuser);
    assign in_ins    = s_axis_tdata[31:0];
    assign in_maddr  = s_axis_tdata[47:32];
    assign in_mbyte  = s_axis_tdata[55:48];
    assign in_ridx   = s_axis_tdata[60:56];
    assign rd_addr_a = (in_cmd == rsic_pkg::CMD_RD_REG) ? in_ridx : in_ins[25:21];
    assign rd_addr_b = in_ins[20:16];
    assign accept    = s_axis_tvalid && s_axis_tready;

    // Architectural state and pipeline control.
    logic [31:0] r_pc;
    logic        r_halt;
    logic        r_b_valid, n_b_valid;
    logic        r_c_valid, n_c_valid;
    logic        r_out_valid, n_out_valid;
    logic        out_free;
    logic        b_done, b_to_c, c_done;

    // Register file: a memory with two read ports and one write port.
    logic [31:0] r_rf [32];
    logic [31:0] r_rf_a, r_rf_b;
    logic [31:0] r_rf_vld;
    logic        rf_we;
    logic [4:0]  rf_waddr;
    logic [31:0] rf_wdata;
    logic        r_a_fwd, r_b_fwd, r_a_vld, r_b_vld;
    logic [31:0] r_fwd_data;

    // Execute stage item.
    rsic_pkg::t_cmd r_b_cmd;
    logic [31:0]    r_b_ins;
    logic [15:0]    r_b_maddr;
    logic [7:0]     r_b_mbyte;
    logic [31:0]    op_a, op_b;

    // Execute stage results.
    rsic_pkg::t_status ex_status;
    logic [31:0]       ex_readv;
    logic              ex_wr;
    logic [4:0]        ex_dreg;
    logic [31:0]       ex_dval;
    logic [31:0]       ex_pc;
    logic              ex_halt_set;
    logic              ex_lw, ex_sw, ex_bwr, ex_brd;
    logic              ex_mem_rd;
    logic [31:0]       ea;
    logic [AW-1:0]     mem_base;
    logic [RW-1:0]     row_a;
    logic [1:0]        off;

    // Data memory banks.
    logic [7:0]    r_rdata [4];
    logic [RW-1:0] bank_row [4];
    logic [7:0]    bank_wdata [4];
    logic [3:0]    bank_we;

    // Memory completion stage.
    logic              r_c_lw;
    logic [1:0]        r_c_off;
    logic [4:0]        r_c_dreg;
    rsic_pkg::t_status r_c_status;
    logic              c_wr;
    logic [31:0]       c_word;

    // Output register.
    logic [31:0]       r_out_pc;
    rsic_pkg::t_status r_out_status;
    logic [31:0]       r_out_readv;
    logic              r_out_wr;
    logic [4:0]        r_out_dreg;
    logic [31:0]       r_out_dval;

    // An item may enter when the execute stage empties and no load is pending
    // in the completion stage, or when either finishes on this edge.
    assign out_free      = !r_out_valid || m_axis_tready;
    assign b_to_c        = r_b_valid && ex_mem_rd;
    assign b_done        = r_b_valid && !ex_mem_rd && out_free;
    assign c_done        = r_c_valid && out_free;
    assign s_axis_tready = (!r_b_valid || b_done) && (!r_c_valid || c_done);

    // Register file storage. Reads happen on the accept edge; a write on the
    // same edge returns the old word, so the write is captured for bypass.
    always_ff @(posedge i_clk) begin
        if (rf_we) begin
            r_rf[rf_waddr] <= rf_wdata;
        end
        if (accept) begin
            r_rf_a <= r_rf[rd_addr_a];
            r_rf_b <= r_rf[rd_addr_b];
        end
    end

    // Entries never written read as zero; register 0 is never written.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rf_vld <= '0;
        end else if (rf_we) begin
            r_rf_vld[rf_waddr] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_a_fwd    <= rf_we && (rf_waddr == rd_addr_a);
            r_b_fwd    <= rf_we && (rf_waddr == rd_addr_b);
            r_a_vld    <= r_rf_vld[rd_addr_a];
            r_b_vld    <= r_rf_vld[rd_addr_b];
            r_fwd_data <= rf_wdata;
            r_b_cmd    <= in_cmd;
            r_b_ins    <= in_ins;
            r_b_maddr  <= in_maddr;
            r_b_mbyte  <= in_mbyte;
        end
    end

    assign op_a = r_a_fwd ? r_fwd_data : (r_a_vld ? r_rf_a : 32'd0);
    assign op_b = r_b_fwd ? r_fwd_data : (r_b_vld ? r_rf_b : 32'd0);

    // Execute: decode, ALU, branch target and data address.
    always_comb begin
        logic [5:0]  op;
        logic [4:0]  rt;
        logic [4:0]  rd;
        logic [31:0] imm;
        logic [31:0] seq;
        logic        legal;

        op    = r_b_ins[31:26];
        rt    = r_b_ins[20:16];
        rd    = r_b_ins[15:11];
        imm   = {{16{r_b_ins[15]}}, r_b_ins[15:0]};
        seq   = r_pc + 32'd4;
        legal = 1'b1;

        ex_status   = r_halt ? rsic_pkg::ST_HALTED : rsic_pkg::ST_OK;
        ex_readv    = 32'd0;
        ex_wr       = 1'b0;
        ex_dreg     = 5'd0;
        ex_dval     = 32'd0;
        ex_pc       = r_pc;
        ex_halt_set = 1'b0;
        ex_lw       = 1'b0;
        ex_sw       = 1'b0;
        ex_bwr      = 1'b0;
        ex_brd      = 1'b0;

        unique case (r_b_cmd)
            rsic_pkg::CMD_WR_BYTE: begin
                ex_bwr = 1'b1;
            end
            rsic_pkg::CMD_RD_BYTE: begin
                ex_brd = 1'b1;
            end
            rsic_pkg::CMD_RD_REG: begin
                ex_readv = op_a;
            end
            rsic_pkg::CMD_EXEC: begin
                if (r_halt) begin
                    ex_status = rsic_pkg::ST_HALTED;
                end else if (r_b_ins == rsic_pkg::WORD_HALT) begin
                    ex_halt_set = 1'b1;
                    ex_status   = rsic_pkg::ST_HALTED;
                end else begin
                    unique case (op)
                        rsic_pkg::OP_RTYPE: begin
                            ex_dreg = rd;
                            ex_wr   = 1'b1;
                            unique case (r_b_ins[2:0])
                                rsic_pkg::FN_ADDU: ex_dval = op_a + op_b;
                                rsic_pkg::FN_SUBU: ex_dval = op_a - op_b;
                                rsic_pkg::FN_AND:  ex_dval = op_a & op_b;
                                rsic_pkg::FN_OR:   ex_dval = op_a | op_b;
                                rsic_pkg::FN_NOR:  ex_dval = ~(op_a | op_b);
                                default:           legal = 1'b0;
                            endcase
                        end
                        rsic_pkg::OP_ADDIU: begin
                            ex_dreg = rt;
                            ex_dval = op_a + imm;
                            ex_wr   = 1'b1;
                        end
                        rsic_pkg::OP_BEQ: begin
                            if (op_a == op_b) begin
                                seq = seq + {imm[29:0], 2'b00};
                            end
                        end
                        rsic_pkg::OP_LW: begin
                            // The register write happens when the data returns.
                            ex_lw   = 1'b1;
                            ex_dreg = rt;
                        end
                        rsic_pkg::OP_SW: begin
                            ex_sw = 1'b1;
                        end
                        rsic_pkg::OP_J: begin
                            seq = {seq[31:28], r_b_ins[25:0], 2'b00};
                        end
                        default: begin
                            legal = 1'b0;
                        end
                    endcase

                    if (legal) begin
                        ex_pc = seq;
                    end else begin
                        ex_status = rsic_pkg::ST_ILLEGAL;
                        ex_wr     = 1'b0;
                    end
                end
            end
            default: begin
                ex_status = rsic_pkg::ST_ILLEGAL;
            end
        endcase

        if (!ex_wr || (ex_dreg == 5'd0)) begin
            ex_wr = 1'b0;
            if (!ex_lw) begin
                ex_dreg = 5'd0;
            end
            ex_dval = 32'd0;
        end
    end

    assign ex_mem_rd = ex_lw || ex_brd;
    assign ea        = op_a + {{16{r_b_ins[15]}}, r_b_ins[15:0]};
    assign mem_base  = (r_b_cmd == rsic_pkg::CMD_EXEC) ? ea[AW-1:0]
                                                       : AW'(32'(r_b_maddr));
    assign row_a     = mem_base[AW-1:2];
    assign off       = mem_base[1:0];

    // Byte i of a word lives in bank (off + i) mod 4; banks below the start
    // offset hold bytes that spill into the next row.
    for (genvar k = 0; k < 4; k++) begin : g_bank
        logic [7:0] mem [ROWS];
        logic [1:0] sel;

        assign sel           = ~(2'(k) - off);
        assign bank_row[k]   = ((ex_lw || ex_sw) && (2'(k) < off)) ? row_a + RW'(1) : row_a;
        assign bank_wdata[k] = ex_sw ? op_b[8*sel +: 8] : r_b_mbyte;
        assign bank_we[k]    = b_done && (ex_sw || (ex_bwr && (off == 2'(k))));

        always_ff @(posedge i_clk) begin
            if (bank_we[k]) begin
                mem[bank_row[k]] <= bank_wdata[k];
            end
            if (b_to_c) begin
                r_rdata[k] <= mem[bank_row[k]];
            end
        end
    end

    // Memory completion stage.
    always_ff @(posedge i_clk) begin
        if (b_to_c) begin
            r_c_lw     <= ex_lw;
            r_c_off    <= off;
            r_c_dreg   <= ex_dreg;
            r_c_status <= ex_status;
        end
    end

    assign c_word = {r_rdata[r_c_off], r_rdata[r_c_off + 2'd1],
                     r_rdata[r_c_off + 2'd2], r_rdata[r_c_off + 2'd3]};
    assign c_wr   = r_c_lw && (r_c_dreg != 5'd0);

    // Single register write port, shared by execute and load completion.
    always_comb begin
        rf_we    = 1'b0;
        rf_waddr = ex_dreg;
        rf_wdata = ex_dval;
        if (c_done && c_wr) begin
            rf_we    = 1'b1;
            rf_waddr = r_c_dreg;
            rf_wdata = c_word;
        end else if (b_done && ex_wr) begin
            rf_we = 1'b1;
        end
    end

    // Control state.
    always_comb begin
        n_b_valid = r_b_valid;
        if (accept) begin
            n_b_valid = 1'b1;
        end else if (b_done || b_to_c) begin
            n_b_valid = 1'b0;
        end

        n_c_valid = r_c_valid;
        if (b_to_c) begin
            n_c_valid = 1'b1;
        end else if (c_done) begin
            n_c_valid = 1'b0;
        end

        n_out_valid = r_out_valid;
        if (b_done || c_done) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid   <= 1'b0;
            r_c_valid   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pc        <= 32'd0;
            r_halt      <= 1'b0;
        end else begin
            r_b_valid   <= n_b_valid;
            r_c_valid   <= n_c_valid;
            r_out_valid <= n_out_valid;
            if (b_done || b_to_c) begin
                r_pc <= ex_pc;
                if (ex_halt_set) begin
                    r_halt <= 1'b1;
                end
            end
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (c_done) begin
            r_out_pc     <= r_pc;
            r_out_status <= r_c_status;
            r_out_readv  <= r_c_lw ? 32'd0 : 32'(r_rdata[r_c_off]);
            r_out_wr     <= c_wr;
            r_out_dreg   <= c_wr ? r_c_dreg : 5'd0;
            r_out_dval   <= c_wr ? c_word : 32'd0;
        end else if (b_done) begin
            r_out_pc     <= ex_pc;
            r_out_status <= ex_status;
            r_out_readv  <= ex_readv;
            r_out_wr     <= ex_wr;
            r_out_dreg   <= ex_dreg;
            r_out_dval   <= ex_dval;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_dval, r_out_dreg, r_out_wr, r_out_readv,
                            r_out_status, r_out_pc};

`ifndef SYNTHESIS
    // Only one item is ever between the register read and the memory return.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_b_valid && r_c_valid))
        else $error("execute and load completion stages both occupied");

    // Register 0 must never be marked as written.
    a_zero_reg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_rf_vld[0])
        else $error("register 0 was written");

    // The pc moves only when an item leaves the execute stage.
    a_pc_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_b_valid |=> $stable(r_pc))
        else $error("pc changed with no item in execute");

    // Once halted, the core stays halted until reset.
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_halt |=> r_halt)
        else $error("halted flag cleared without reset");
`endif

endmodule

// ===== sim/risc_subset_instruction_core_monitor.sv =====
`timescale 1ns / 100ps

// Watches both stream channels of the core. Every accepted input item is run
// through a shadow copy of the architectural state to form the expected result,
// and every accepted output item is compared field by field with the oldest
// expected result still waiting.
module risc_subset_instruction_core_monitor (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_in_tvalid,
    input  logic         i_in_tready,
    // instruction[31:0], mem_address[47:32], mem_byte[55:48], reg_index[60:56], zero
    input  logic [63:0]  i_in_tdata,
    // command[1:0]
    input  logic [1:0]   i_in_tuser,
    input  logic         i_out_tvalid,
    input  logic         i_out_tready,
    // next_pc[31:0], status[33:32], read_value[65:34], reg_written[66],
    // dest_reg[71:67], dest_value[103:72]
    input  logic [103:0] i_out_tdata,
    output int           o_mismatches,
    output int           o_outstanding
);

    typedef struct packed {
        logic [31:0]       next_pc;
        rsic_pkg::t_status status;
        logic [31:0]       read_value;
        logic              reg_written;
        logic [4:0]        dest_reg;
        logic [31:0]       dest_value;
    } t_core_result;

    logic [31:0]  shadow_pc;
    logic [31:0]  shadow_regs [0:31];
    logic [7:0]   shadow_mem [0:rsic_pkg::DataBytesDef-1];
    logic         shadow_halted;
    t_core_result result_fifo [$];

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
    end

    // Big-endian word, each byte wrapping to the memory size on its own.
    function automatic logic [31:0] read_word(input logic [31:0] addr);
        logic [31:0] base;
        logic [31:0] word;
        base = addr % rsic_pkg::DataBytesDef;
        word = '0;
        for (int unsigned i = 0; i < 4; i++) begin
            word = {word[23:0], shadow_mem[(base + i) % rsic_pkg::DataBytesDef]};
        end
        return word;
    endfunction

    function automatic void write_word(input logic [31:0] addr, input logic [31:0] word);
        logic [31:0] base;
        base = addr % rsic_pkg::DataBytesDef;
        for (int unsigned i = 0; i < 4; i++) begin
            shadow_mem[(base + i) % rsic_pkg::DataBytesDef] = word[31 - 8 * i -: 8];
        end
    endfunction

    function automatic t_core_result shadow_execute(input rsic_pkg::t_cmd cmd,
                                                    input logic [31:0] instr,
                                                    input logic [15:0] maddr,
                                                    input logic [7:0] mbyte,
                                                    input logic [4:0] ridx);
        t_core_result res;
        logic [5:0]   opcode;
        logic [4:0]   rs;
        logic [4:0]   rt;
        logic [4:0]   dst;
        logic [31:0]  a;
        logic [31:0]  b;
        logic [31:0]  imm;
        logic [31:0]  seq;
        logic [31:0]  val;
        logic         wr;
        logic         legal;
        res = '0;
        res.status = shadow_halted ? rsic_pkg::ST_HALTED : rsic_pkg::ST_OK;
        wr  = 1'b0;
        dst = '0;
        val = '0;
        case (cmd)
            rsic_pkg::CMD_WR_BYTE:
                shadow_mem[maddr % rsic_pkg::DataBytesDef] = mbyte;
            rsic_pkg::CMD_RD_BYTE:
                res.read_value = {24'd0, shadow_mem[maddr % rsic_pkg::DataBytesDef]};
            rsic_pkg::CMD_RD_REG:
                res.read_value = shadow_regs[ridx];
            default: begin
                if (shadow_halted) begin
                    // A halted core ignores instructions.
                    res.status = rsic_pkg::ST_HALTED;
                end else if (instr == rsic_pkg::WORD_HALT) begin
                    shadow_halted = 1'b1;
                    res.status    = rsic_pkg::ST_HALTED;
                end else begin
                    opcode = instr[31:26];
                    rs     = instr[25:21];
                    rt     = instr[20:16];
                    a      = shadow_regs[rs];
                    b      = shadow_regs[rt];
                    imm    = {{16{instr[15]}}, instr[15:0]};
                    seq    = shadow_pc + 32'd4;
                    legal  = 1'b1;
                    case (opcode)
                        rsic_pkg::OP_RTYPE: begin
                            dst = instr[15:11];
                            wr  = 1'b1;
                            case (instr[2:0])
                                rsic_pkg::FN_ADDU: val = a + b;
                                rsic_pkg::FN_SUBU: val = a - b;
                                rsic_pkg::FN_AND:  val = a & b;
                                rsic_pkg::FN_OR:   val = a | b;
                                rsic_pkg::FN_NOR:  val = ~(a | b);
                                default:           legal = 1'b0;
                            endcase
                        end
                        rsic_pkg::OP_ADDIU: begin
                            dst = rt;
                            val = a + imm;
                            wr  = 1'b1;
                        end
                        rsic_pkg::OP_BEQ: begin
                            if (a == b) begin
                                seq = seq + (imm << 2);
                            end
                        end
                        rsic_pkg::OP_LW: begin
                            dst = rt;
                            val = read_word(a + imm);
                            wr  = 1'b1;
                        end
                        rsic_pkg::OP_SW: write_word(a + imm, b);
                        rsic_pkg::OP_J:  seq = {seq[31:28], instr[25:0], 2'b00};
                        default:         legal = 1'b0;
                    endcase
                    // An illegal word changes nothing, the pc included.
                    if (!legal) begin
                        res.status = rsic_pkg::ST_ILLEGAL;
                        wr = 1'b0;
                    end else begin
                        shadow_pc = seq;
                    end
                    if (wr && dst != 5'd0) begin
                        shadow_regs[dst] = val;
                    end else begin
                        wr = 1'b0;
                    end
                end
            end
        endcase
        res.next_pc     = shadow_pc;
        res.reg_written = wr;
        res.dest_reg    = wr ? dst : 5'd0;
        res.dest_value  = wr ? val : 32'd0;
        return res;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        o_mismatches++;
        $display("%0t monitor: %s got %h expected %h", $realtime, what, got, want);
    endtask

    always @(posedge i_clk) begin
        t_core_result got;
        t_core_result want;
        if (!i_rst_n) begin
            shadow_pc     = '0;
            shadow_halted = 1'b0;
            for (int i = 0; i < 32; i++) begin
                shadow_regs[i] = '0;
            end
            result_fifo.delete();
        end else begin
            // Results pass the execute stage and output register before they leave, so
            // the output side is settled before this edge's input item is added.
            if (i_out_tvalid && i_out_tready) begin
                got.next_pc     = i_out_tdata[31:0];
                got.status      = rsic_pkg::t_status'(i_out_tdata[33:32]);
                got.read_value  = i_out_tdata[65:34];
                got.reg_written = i_out_tdata[66];
                got.dest_reg    = i_out_tdata[71:67];
                got.dest_value  = i_out_tdata[103:72];
                if (result_fifo.size() == 0) begin
                    report_mismatch("result with nothing pending, next_pc", got.next_pc, 'x);
                end else begin
                    want = result_fifo.pop_front();
                    if (got.next_pc !== want.next_pc)
                        report_mismatch("next_pc", got.next_pc, want.next_pc);
                    if (got.status !== want.status)
                        report_mismatch("status", got.status, want.status);
                    if (got.read_value !== want.read_value)
                        report_mismatch("read_value", got.read_value, want.read_value);
                    if (got.reg_written !== want.reg_written)
                        report_mismatch("reg_written", got.reg_written, want.reg_written);
                    if (got.dest_reg !== want.dest_reg)
                        report_mismatch("dest_reg", got.dest_reg, want.dest_reg);
                    if (got.dest_value !== want.dest_value)
                        report_mismatch("dest_value", got.dest_value, want.dest_value);
                end
            end
            if (i_in_tvalid && i_in_tready) begin
                result_fifo.push_back(shadow_execute(rsic_pkg::t_cmd'(i_in_tuser),
                                                     i_in_tdata[31:0],
                                                     i_in_tdata[47:32], i_in_tdata[55:48],
                                                     i_in_tdata[60:56]));
            end
        end
        o_outstanding = result_fifo.size();
    end

endmodule

// ===== sim/risc_subset_instruction_core_tb.sv =====
`timescale 1ns / 100ps

// Drives the core with a data memory preload of a window around address zero,
// a short directed program, a long random instruction mix and a closing halted
// phase. Checking is done by the monitor instance; this module only makes
// stimulus and the verdict.
module risc_subset_instruction_core_tb;

    localparam int IdleLimit   = 1000;
    localparam int DrainCycles = 20;
    localparam int RandomItems = 1150;
    // The preloaded window runs from -WindowHalf to WindowHalf - 1, wrapped.
    localparam int WindowHalf  = 64;

    logic         clk           = 1'b0;
    logic         rst_n         = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    // instruction[31:0], mem_address[47:32], mem_byte[55:48], reg_index[60:56], zero
    logic [63:0]  s_axis_tdata  = '0;
    // command[1:0]
    logic [1:0]   s_axis_tuser  = rsic_pkg::CMD_EXEC;
    logic         m_axis_tready = 1'b0;
    logic         s_axis_tready;
    logic         m_axis_tvalid;
    // next_pc[31:0], status[33:32], read_value[65:34], reg_written[66],
    // dest_reg[71:67], dest_value[103:72]
    logic [103:0] m_axis_tdata;

    int mismatches;
    int outstanding;
    int burst_left  = 0;
    int idle_cycles = 0;
    int rx_mode     = 0;
    int rx_left     = 0;

    always #2 clk = ~clk;

    risc_subset_instruction_core uut (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    risc_subset_instruction_core_monitor u_monitor (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in_tvalid   (s_axis_tvalid),
        .i_in_tready   (s_axis_tready),
        .i_in_tdata    (s_axis_tdata),
        .i_in_tuser    (s_axis_tuser),
        .i_out_tvalid  (m_axis_tvalid),
        .i_out_tready  (m_axis_tready),
        .i_out_tdata   (m_axis_tdata),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    // The receiver switches between always ready, randomly ready and short
    // full stalls, each held for a random stretch.
    always @(posedge clk) begin
        if (rx_left == 0) begin
            rx_mode = $urandom_range(0, 2);
            rx_left = (rx_mode == 2) ? $urandom_range(1, 12) : $urandom_range(8, 64);
        end
        rx_left--;
        case (rx_mode)
            0:       m_axis_tready <= 1'b1;
            1:       m_axis_tready <= ($urandom_range(0, 3) != 0);
            default: m_axis_tready <= 1'b0;
        endcase
    end

    // A run that stops moving items on both channels is a hang.
    always @(posedge clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IdleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Offers one item and returns at the edge that accepts it. Items go out in
    // bursts; between bursts the valid is usually dropped for a random gap.
    task automatic send_item(input rsic_pkg::t_cmd cmd, input logic [31:0] instr,
                             input logic [15:0] maddr, input logic [7:0] mbyte,
                             input logic [4:0] ridx);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0) begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= {3'b000, ridx, mbyte, maddr, instr};
        do @(posedge clk); while (!s_axis_tready);
    endtask

    // Instruction words; unused fields are sent with the noise fields random.
    task automatic send_exec(input logic [31:0] instr);
        send_item(rsic_pkg::CMD_EXEC, instr, 16'($urandom), 8'($urandom), 5'($urandom));
    endtask

    task automatic send_mem(input rsic_pkg::t_cmd cmd, input logic [15:0] maddr,
                            input logic [7:0] mbyte);
        send_item(cmd, $urandom, maddr, mbyte, 5'($urandom));
    endtask

    task automatic send_reg_read(input logic [4:0] ridx);
        send_item(rsic_pkg::CMD_RD_REG, $urandom, 16'($urandom), 8'($urandom), ridx);
    endtask

    // The shift amount and the upper funct bits do not select anything, so they
    // are random.
    function automatic logic [31:0] r_word(input logic [4:0] rs, input logic [4:0] rt,
                                           input logic [4:0] rd, input logic [2:0] fn);
        return {rsic_pkg::OP_RTYPE, rs, rt, rd, 5'($urandom), 3'($urandom), fn};
    endfunction

    function automatic logic [31:0] i_word(input logic [5:0] op, input logic [4:0] rs,
                                           input logic [4:0] rt, input logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Half of the stores use low base registers with short offsets; the rest go
    // anywhere in the address space.
    function automatic logic [31:0] mem_word(input logic [5:0] op);
        if ($urandom_range(0, 1) == 0) begin
            return i_word(op, 5'($urandom_range(0, 3)), 5'($urandom),
                          16'($urandom_range(0, 32) - 16));
        end
        return i_word(op, 5'($urandom), 5'($urandom), 16'($urandom));
    endfunction

    // Loads use register zero as the base, so every byte they touch lies in
    // the preloaded window around address zero.
    function automatic logic [31:0] load_instr();
        return i_word(rsic_pkg::OP_LW, 5'd0, 5'($urandom),
                      16'($urandom_range(0, 2 * WindowHalf - 4) - WindowHalf));
    endfunction

    function automatic logic [31:0] random_instruction();
        int          pick;
        logic [5:0]  op;
        logic [4:0]  rs;
        logic [2:0]  fn;
        logic [31:0] w;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            case ($urandom_range(0, 4))
                0:       fn = rsic_pkg::FN_ADDU;
                1:       fn = rsic_pkg::FN_SUBU;
                2:       fn = rsic_pkg::FN_AND;
                3:       fn = rsic_pkg::FN_OR;
                default: fn = rsic_pkg::FN_NOR;
            endcase
            return r_word(5'($urandom), 5'($urandom), 5'($urandom), fn);
        end else if (pick < 55) begin
            return i_word(rsic_pkg::OP_ADDIU, 5'($urandom), 5'($urandom), 16'($urandom));
        end else if (pick < 65) begin
            // Equal source registers make most branches taken.
            rs = 5'($urandom);
            return i_word(rsic_pkg::OP_BEQ, rs,
                          ($urandom_range(0, 1) == 0) ? rs : 5'($urandom),
                          16'($urandom));
        end else if (pick < 75) begin
            return load_instr();
        end else if (pick < 85) begin
            return mem_word(rsic_pkg::OP_SW);
        end else if (pick < 89) begin
            return {rsic_pkg::OP_J, 26'($urandom)};
        end else if (pick < 93) begin
            // Low funct bits that name no operation.
            case ($urandom_range(0, 2))
                0:       fn = 3'd0;
                1:       fn = 3'd2;
                default: fn = 3'd6;
            endcase
            return r_word(5'($urandom), 5'($urandom), 5'($urandom), fn);
        end else if (pick < 97) begin
            do op = 6'($urandom);
            while (op inside {rsic_pkg::OP_RTYPE, rsic_pkg::OP_J, rsic_pkg::OP_BEQ,
                              rsic_pkg::OP_ADDIU, rsic_pkg::OP_LW, rsic_pkg::OP_SW});
            return {op, 26'($urandom)};
        end
        // Any word but a load, whose base register could point anywhere.
        do w = $urandom;
        while (w[31:26] == rsic_pkg::OP_LW);
        return w;
    endfunction

    initial begin
        logic [31:0] instr;
        logic [15:0] addr;
        int          pick;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // The data memory is undefined until written, so the window that loads
        // and byte reads use is given values first.
        for (int a = 0; a < 2 * WindowHalf; a++) begin
            send_mem(rsic_pkg::CMD_WR_BYTE, 16'(a - WindowHalf), 8'($urandom));
        end

        // Directed program: operand extremes, every operation, register zero,
        // illegal words, wrapping addresses and branch and jump extremes.
        send_reg_read(5'd31);
        send_exec(i_word(rsic_pkg::OP_ADDIU, 5'd0, 5'd1, 16'h7FFF));
        send_exec(i_word(rsic_pkg::OP_ADDIU, 5'd0, 5'd2, 16'h8000));
        send_exec(i_word(rsic_pkg::OP_ADDIU, 5'd1, 5'd0, 16'h0001));
        send_exec(r_word(5'd1, 5'd2, 5'd3, rsic_pkg::FN_ADDU));
        send_exec(r_word(5'd2, 5'd1, 5'd4, rsic_pkg::FN_SUBU));
        send_exec(r_word(5'd1, 5'd2, 5'd5, rsic_pkg::FN_AND));
        send_exec(r_word(5'd1, 5'd2, 5'd6, rsic_pkg::FN_OR));
        send_exec(r_word(5'd0, 5'd0, 5'd31, rsic_pkg::FN_NOR));
        send_exec(r_word(5'd1, 5'd2, 5'd7, 3'd0));
        send_exec(r_word(5'd1, 5'd2, 5'd7, 3'd2));
        send_exec(r_word(5'd1, 5'd2, 5'd7, 3'd6));
        send_exec({6'h3F, 26'd0});
        // A word at address all ones wraps past the end of the memory.
        send_exec(i_word(rsic_pkg::OP_LW, 5'd0, 5'd8, 16'hFFFF));
        send_exec(i_word(rsic_pkg::OP_SW, 5'd1, 5'd31, 16'h7FFE));
        send_exec(i_word(rsic_pkg::OP_LW, 5'd1, 5'd9, 16'h7FFE));
        send_mem(rsic_pkg::CMD_RD_BYTE, 16'hFFFF, 8'($urandom));
        send_mem(rsic_pkg::CMD_WR_BYTE, 16'h0000, 8'hFF);
        send_mem(rsic_pkg::CMD_RD_BYTE, 16'h0000, 8'($urandom));
        send_exec(i_word(rsic_pkg::OP_BEQ, 5'd1, 5'd2, 16'h0005));
        send_exec(i_word(rsic_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFFE));
        // The most negative offset carries the pc below zero, so the jumps
        // that follow keep a nonzero upper nibble.
        send_exec(i_word(rsic_pkg::OP_BEQ, 5'd0, 5'd0, 16'h8000));
        send_exec({rsic_pkg::OP_J, 26'h3FF_FFFF});
        send_exec({rsic_pkg::OP_J, 26'h000_0000});
        send_reg_read(5'd0);
        send_reg_read(5'd9);

        // Random mix, mostly instructions.
        for (int n = 0; n < RandomItems; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                do instr = random_instruction();
                while (instr == rsic_pkg::WORD_HALT);
                send_exec(instr);
            end else if (pick < 83) begin
                send_mem(rsic_pkg::CMD_WR_BYTE, 16'($urandom), 8'($urandom));
            end else if (pick < 91) begin
                send_mem(rsic_pkg::CMD_RD_BYTE,
                         16'($urandom_range(0, 2 * WindowHalf - 1) - WindowHalf),
                         8'($urandom));
            end else begin
                send_reg_read(5'($urandom));
            end
        end

        // Halt comes last since only reset leaves the halted state. Afterwards
        // instructions are ignored while the other commands still work.
        send_exec(rsic_pkg::WORD_HALT);
        for (int n = 0; n < 4; n++) begin
            send_exec(random_instruction());
        end
        addr = 16'($urandom);
        send_mem(rsic_pkg::CMD_WR_BYTE, addr, 8'($urandom));
        send_mem(rsic_pkg::CMD_RD_BYTE, addr, 8'($urandom));
        send_reg_read(5'($urandom));
        send_reg_read(5'd31);
        send_exec(rsic_pkg::WORD_HALT);
        s_axis_tvalid <= 1'b0;

        // The monitor takes in the last item at the accepting edge; look from the next edge on.
        @(posedge clk);
        wait (outstanding == 0);
        repeat (DrainCycles) @(posedge clk);
        if (mismatches == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
